// ===== rtl/comma_token_hex_command_framer_unit_defines.svh =====
// Assertion macros for the comma token framer.
`ifndef COMMA_TOKEN_HEX_COMMAND_FRAMER_UNIT_DEFINES_SVH
`define COMMA_TOKEN_HEX_COMMAND_FRAMER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CTF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ctf check failed");

// next-cycle implication
`define CTF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ctf check failed");

`endif

// ===== rtl/ctf_pkg.sv =====
// Shared constants, codes and helper functions for the comma token framer.
`timescale 1ns / 1ps
`default_nettype none
package ctf_pkg;

	localparam int TOKEN_MAX_DEF = 7;
	localparam int Q_DEPTH = 2;
	localparam logic [7:0] SEP_CHAR = 8'h2C;

	typedef enum logic {
		CMD_DATA = 1'b0,
		CMD_EOS  = 1'b1
	} cmd_t;

	function automatic logic hex_char_ok(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= "0" && c <= "9") begin
			v = c - 8'h30;
		end else if (c >= "A" && c <= "F") begin
			v = c - 8'h41 + 8'd10;
		end else if (c >= "a" && c <= "f") begin
			v = c - 8'h61 + 8'd10;
		end
		return v[3:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ctf_front.sv =====
// Front end: collects token bytes, tracks hex validity, decodes and hands closed tokens on.
`timescale 1ns / 1ps
`default_nettype none
module ctf_front import ctf_pkg::*; #(
	parameter int TOKEN_MAX = TOKEN_MAX_DEF,
	localparam int LW = $clog2(TOKEN_MAX + 1),
	localparam int IW = $clog2(TOKEN_MAX)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   command,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   q_full,
	output logic                        push,
	output logic [TOKEN_MAX*8-1:0]      push_data,
	output logic [LW-1:0]               push_count
);

	logic [7:0]    store_q [TOKEN_MAX];
	logic [LW-1:0] len_q;
	logic          hex_q;
	logic          accept;
	logic          is_eos;
	logic          is_sep;
	logic          has_room;
	logic          tok_hex;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_eos   = (command == CMD_EOS);
	assign is_sep   = (data_byte == SEP_CHAR);
	assign has_room = (len_q < LW'(TOKEN_MAX));
	assign tok_hex  = hex_q && (len_q >= LW'(2)) && !len_q[0];

	assign push       = accept && (is_eos || is_sep) && (len_q != '0);
	assign push_count = tok_hex ? (len_q >> 1) : len_q;

	// for a hex token, decoded byte j comes from characters 2j and 2j+1; otherwise byte j is character j
	genvar j;
	for (j = 0; j < TOKEN_MAX; j++) begin : g_dec
		if (2 * j + 1 < TOKEN_MAX) begin : g_pair
			assign push_data[j*8 +: 8] = tok_hex ?
				{nibble_of(store_q[2*j]), nibble_of(store_q[2*j+1])} : store_q[j];
		end else begin : g_raw
			assign push_data[j*8 +: 8] = store_q[j];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_eos && !is_sep && has_room) begin
			store_q[len_q[IW-1:0]] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			hex_q <= 1'b1;
		end else if (accept) begin
			if (is_eos || is_sep || !has_room) begin
				// close, flush or overflow: token starts afresh
				len_q <= '0;
				hex_q <= 1'b1;
			end else begin
				len_q <= len_q + LW'(1);
				hex_q <= hex_q && hex_char_ok(data_byte);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ctf_fifo.sv =====
// Short queue of closed tokens between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module ctf_fifo import ctf_pkg::*; #(
	parameter int WIDTH = 8,
	localparam int AW = $clog2(Q_DEPTH),
	localparam int CW = $clog2(Q_DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	logic [WIDTH-1:0] ent_q [Q_DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full    = (cnt_q == CW'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ctf_back.sv =====
// Back end: serialises one queued token as first payload byte, length and remaining payload words.
`timescale 1ns / 1ps
`default_nettype none
module ctf_back import ctf_pkg::*; #(
	parameter int TOKEN_MAX = TOKEN_MAX_DEF,
	localparam int LW = $clog2(TOKEN_MAX + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_empty,
	input  wire logic [TOKEN_MAX*8-1:0] q_data,
	input  wire logic [LW-1:0]          q_count,
	output logic                        q_pop,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [7:0]                  out_byte,
	output logic                        last_of_message
);

	logic [7:0]    sh_q [TOKEN_MAX];
	logic [LW-1:0] cnt_q;
	logic [LW-1:0] k_q;
	logic          active_q;
	logic          ovalid_q;
	logic [7:0]    obyte_q;
	logic          olast_q;
	logic          out_free;
	logic          emit;
	logic          emit_last;

	assign out_free  = !ovalid_q || !out_stall;
	assign emit      = active_q && out_free;
	assign emit_last = emit && (k_q == cnt_q);
	// next token is picked up while idle, or in the cycle the current one sends its last word
	assign q_pop     = (!active_q || emit_last) && !q_empty;

	assign out_valid       = ovalid_q;
	assign out_byte        = obyte_q;
	assign last_of_message = olast_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < TOKEN_MAX; i++) begin
				sh_q[i] <= q_data[i*8 +: 8];
			end
		end else if (emit && (k_q != LW'(1))) begin
			for (int i = 0; i < TOKEN_MAX - 1; i++) begin
				sh_q[i] <= sh_q[i+1];
			end
		end
		if (emit) begin
			obyte_q <= (k_q == LW'(1)) ? (8'(cnt_q) - 8'd1) : sh_q[0];
			olast_q <= (k_q == cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
			k_q      <= '0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (out_free) begin
				ovalid_q <= 1'b0;
			end
			if (q_pop) begin
				active_q <= 1'b1;
				cnt_q    <= q_count;
				k_q      <= '0;
			end else begin
				if (emit_last) begin
					active_q <= 1'b0;
				end
				if (emit) begin
					k_q <= k_q + LW'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/comma_token_hex_command_framer_unit.sv =====
// Top level of the comma token framer: front end, token queue and back end.
// Usage:
//   Input channel (in_valid / in_stall, command, data_byte) takes one script word
//   per cycle while in_stall is low. command = data collects bytes into a token;
//   a comma or an end-of-script word closes it; end of script also clears it.
//   Output channel (out_valid / out_stall, out_byte, last_of_message) gives the
//   message: first payload byte, length byte (bytes - 1), then the rest, last marked.
//   Even-length tokens of hex digits are decoded to bytes, others are sent raw.
// Timing:
//   Once the closing word is accepted, the token goes through the queue and the
//   serialiser to the output register; a token that yields n bytes gives n + 1
//   words, one word a cycle while not stalled, consecutive messages back to back.
//   Input runs at one word a cycle; in_stall rises only while the two-entry
//   token queue is full, i.e. the serialiser falls behind closing words.
// Reset (arst_n low) empties the token, the queue and the output register.
// out_stall holds the current output word and lets the queue fill behind it.
`timescale 1ns / 1ps
`default_nettype none
`include "comma_token_hex_command_framer_unit_defines.svh"
module comma_token_hex_command_framer_unit import ctf_pkg::*; #(
	parameter int TOKEN_MAX = TOKEN_MAX_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       command,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            last_of_message
);

	localparam int LW = $clog2(TOKEN_MAX + 1);
	localparam int EW = TOKEN_MAX * 8 + LW;

	logic                   q_push;
	logic                   q_pop;
	logic                   q_full;
	logic                   q_empty;
	logic [TOKEN_MAX*8-1:0] push_data;
	logic [LW-1:0]          push_count;
	logic [EW-1:0]          rd_entry;

	ctf_front #(.TOKEN_MAX(TOKEN_MAX)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.data_byte  (data_byte),
		.q_full     (q_full),
		.push       (q_push),
		.push_data  (push_data),
		.push_count (push_count)
	);

	ctf_fifo #(.WIDTH(EW)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data ({push_count, push_data}),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (rd_entry),
		.empty   (q_empty)
	);

	ctf_back #(.TOKEN_MAX(TOKEN_MAX)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_data          (rd_entry[TOKEN_MAX*8-1:0]),
		.q_count         (rd_entry[EW-1 -: LW]),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.last_of_message (last_of_message)
	);

	`CTF_ASSERT_IMP(a_q_no_overflow, q_push, !q_full)
	`CTF_ASSERT_IMP(a_q_no_underflow, q_pop, !q_empty)
	// a message never leaves a gap between its words
	`CTF_ASSERT_NXT(a_msg_contiguous, out_valid && !out_stall && !last_of_message, out_valid)

endmodule
`default_nettype wire
